// ===== design/ptps_pkg.sv =====
// ---------------------------------------------------------------------------
// ptps_pkg
// Shared widths, register indexes and types of the punch table plant model.
// ---------------------------------------------------------------------------
package ptps_pkg;

    // shift-add / restoring divide unit
    localparam int OPA_W     = 56;
    localparam int OPB_W     = 20;
    localparam int CNT_W     = 6;
    localparam int MUL_STEPS = 20;
    localparam int DIV_STEPS = 56;

    // ports
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;
    localparam int S_TDATA_W  = 120;
    localparam int M_TDATA_W  = 112;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_ZONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PUNCH_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENC_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PUNCH_DUR   = 3'd6;

    // plant constants
    localparam int FORCE_PER_POWER = 2500;
    localparam int NOISE_DIV       = 100000;
    localparam int VEL_DIV         = 1000000;
    localparam int POS_DIV         = 1000;
    localparam int NOISE_MOD       = 1000;

    typedef struct packed {
        logic             go;
        logic             div;
        logic [OPA_W-1:0] a;
        logic [OPB_W-1:0] b;
    } alu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    typedef struct packed {
        logic [31:0] last_punch_y;
        logic [31:0] last_punch_x;
        logic [31:0] punch_count;
        logic        fail_flag;
        logic        head_up;
        logic        safe_bottom;
        logic        safe_top;
        logic        safe_right;
        logic        safe_left;
        logic [1:0]  enc_y;
        logic [1:0]  enc_x;
    } res_t;

endpackage

// ===== design/punch_table_plant_step_top.sv =====
// ---------------------------------------------------------------------------
// punch_table_plant_step_top
// Two-axis punch table plant, one simulation step per input transfer.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one step: tuser is the mode (0 tick, 1 place head), tdata
//   the tick/placement fields. m_* returns exactly one result per step.
//   cfg_we/cfg_index/cfg_wdata write the seven plant registers; write only
//   while the block is idle. Indexes above six are ignored.
// Step processing:
//   One step at a time. A placement or a tick on a failed table skips the
//   arithmetic. A normal tick runs all products and the constant and
//   encoder divides through one bit-serial unit (20 steps per multiply,
//   56 per divide), 7 operations per axis plus the friction loss, which
//   is shared by both axes.
// Reset:
//   aresetn (synchronous, active low) zeroes positions, speeds, punch state,
//   encoder phases and the fail latch, and loads default register values.
// Stall:
//   The result sits in an output register; the next step is accepted while
//   it waits, and that step's result is held back until the register frees.
// ---------------------------------------------------------------------------
module punch_table_plant_step_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // fields from bit 0: period_us[15:0], power_x[23:16], power_y[31:24],
    // punch_request[32], noise_x[42:33], noise_y[52:43], place_x_nm[84:53],
    // place_y_nm[116:85], zero pad
    input  logic [ptps_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                 s_tuser,   // mode
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // fields from bit 0: enc_x[1:0], enc_y[3:2], safe_left[4], safe_right[5],
    // safe_top[6], safe_bottom[7], head_up[8], fail_flag[9],
    // punch_count[41:10], last_punch_x[73:42], last_punch_y[105:74], zero pad
    output logic [ptps_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_we,
    input  logic [ptps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ptps_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    typedef enum logic [18:0] {
        S_IDLE    = 19'h00001,
        S_LOSS_GO = 19'h00002,
        S_LOSS_M  = 19'h00004,
        S_LOSS_D  = 19'h00008,
        S_FORCE   = 19'h00010,
        S_N_GO    = 19'h00020,
        S_N_M     = 19'h00040,
        S_N_D     = 19'h00080,
        S_P_GO    = 19'h00100,
        S_P_M     = 19'h00200,
        S_P_D     = 19'h00400,
        S_FRIC    = 19'h00800,
        S_V_GO    = 19'h01000,
        S_V_M     = 19'h02000,
        S_V_D     = 19'h04000,
        S_G_GO    = 19'h08000,
        S_G_D     = 19'h10000,
        S_CHECK   = 19'h20000,
        S_REPORT  = 19'h40000
    } state_t;

    // configuration
    logic [29:0] area_w_reg, area_h_reg;
    logic [26:0] safe_zone_reg, punch_dur_reg;
    logic [19:0] punch_max_reg, enc_period_reg, friction_reg;

    // plant state
    logic signed [31:0] pos_reg   [2];
    logic signed [31:0] speed_reg [2];
    logic [1:0]         enc_reg   [2];
    logic signed [31:0] pos_next   [2];
    logic signed [31:0] speed_next [2];
    logic [1:0]         enc_next   [2];
    logic               failed_reg, failed_next;
    logic signed [31:0] ptl_reg, ptl_next;
    logic [31:0]        count_reg, count_next;
    logic [31:0]        last_x_reg, last_x_next, last_y_reg, last_y_next;

    // control and working registers
    state_t             state_reg, state_next;
    logic               axis_reg, axis_next;
    logic               neg_reg, neg_next;
    logic signed [36:0] frc_reg, frc_next;
    logic signed [31:0] v_reg, v_next;
    logic [26:0]        loss_reg, loss_next;

    // step item
    logic               mode_in, req_in;
    logic [15:0]        period_reg, period_next;
    logic signed [7:0]  pwx_reg, pwx_next, pwy_reg, pwy_next;
    logic               req_reg, req_next;
    logic [9:0]         nx_reg, nx_next, ny_reg, ny_next;
    logic [9:0]         nx_raw, ny_raw;

    // output register
    ptps_pkg::res_t     out_reg, out_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               out_free;

    ptps_pkg::alu_cmd_t  alu_cmd;
    ptps_pkg::alu_stat_t alu_st;
    logic [ptps_pkg::OPA_W-1:0] alu_res;

    // datapath helpers
    logic signed [7:0]  pw_sel;
    logic [9:0]         noise_sel;
    logic signed [33:0] t34;
    logic signed [36:0] f37;
    logic [36:0]        frc_mag;
    logic [31:0]        v_mag, pos_mag;
    logic               v_zero;
    logic signed [31:0] v_fric;
    logic [17:0]        enc_w;
    logic [1:0]         ph, ql;

    // step checks
    logic               out_x, out_y, too_fast, chk_head, chk_fail;
    logic signed [31:0] chk_ptl, ptl_dec;
    logic [31:0]        chk_count, chk_last_x, chk_last_y, spd_mag_x, spd_mag_y;
    logic signed [33:0] low_lim, hi_x, hi_y, px34, py34;
    logic               rep_head;

    ptps_muldiv u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (alu_cmd),
        .stat    (alu_st),
        .result  (alu_res)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign mode_in  = s_tuser;
    assign req_in   = s_tdata[32];
    assign nx_raw   = s_tdata[42:33];
    assign ny_raw   = s_tdata[52:43];

    // axis-selected operands
    assign pw_sel    = axis_reg ? pwy_reg : pwx_reg;
    assign noise_sel = axis_reg ? ny_reg : nx_reg;
    assign t34 = 34'(pw_sel) * 34'(ptps_pkg::FORCE_PER_POWER)
               - 34'(speed_reg[axis_reg]);
    assign f37 = (37'(t34) <<< 2) + 37'(t34);
    assign frc_mag = frc_reg[36] ? 37'(-frc_reg) : 37'(frc_reg);
    assign v_mag   = v_reg[31] ? 32'(-v_reg) : 32'(v_reg);
    assign pos_mag = pos_reg[axis_reg][31] ? 32'(-pos_reg[axis_reg])
                                           : 32'(pos_reg[axis_reg]);
    assign v_zero  = (v_mag <= 32'd1) || (v_mag <= 32'(loss_reg));
    assign v_fric  = v_zero ? 32'sd0
                   : (v_reg[31] ? v_reg + $signed(32'(loss_reg))
                                : v_reg - $signed(32'(loss_reg)));
    assign enc_w   = enc_period_reg[19:2];
    assign ql      = alu_res[1:0];
    assign ph      = neg_reg ? 2'(-ql) : ql;

    // limits and punch bookkeeping for the end of a tick
    assign px34    = 34'(pos_reg[0]);
    assign py34    = 34'(pos_reg[1]);
    assign low_lim = -$signed({7'b0, safe_zone_reg});
    assign hi_x    = $signed({4'b0, area_w_reg}) + $signed({7'b0, safe_zone_reg});
    assign hi_y    = $signed({4'b0, area_h_reg}) + $signed({7'b0, safe_zone_reg});
    assign out_x   = (px34 < low_lim) || (px34 > hi_x);
    assign out_y   = (py34 < low_lim) || (py34 > hi_y);
    assign spd_mag_x = speed_reg[0][31] ? 32'(-speed_reg[0]) : 32'(speed_reg[0]);
    assign spd_mag_y = speed_reg[1][31] ? 32'(-speed_reg[1]) : 32'(speed_reg[1]);
    assign too_fast  = (spd_mag_x > 32'(punch_max_reg))
                    || (spd_mag_y > 32'(punch_max_reg));
    assign ptl_dec   = ptl_reg - $signed({16'b0, period_reg});
    assign rep_head  = (ptl_reg == 32'sd0);

    always_comb begin
        chk_fail   = failed_reg | out_x | out_y;
        chk_head   = 1'b0;
        chk_ptl    = ptl_reg;
        chk_count  = count_reg;
        chk_last_x = last_x_reg;
        chk_last_y = last_y_reg;
        if (req_reg) begin
            if (ptl_reg > 32'sd0 || too_fast) begin
                chk_fail = 1'b1;
            end else begin
                chk_last_x = pos_reg[0];
                chk_last_y = pos_reg[1];
                chk_ptl    = $signed({5'b0, punch_dur_reg});
            end
        end else if (ptl_reg > 32'sd0) begin
            chk_ptl = ptl_dec;
            if (too_fast) begin
                chk_fail = 1'b1;
            end else if (ptl_dec <= 32'sd0) begin
                chk_head  = 1'b1;
                chk_ptl   = 32'sd0;
                chk_count = count_reg + 32'd1;
            end
        end else begin
            chk_head = 1'b1;
        end
    end

    // bit-serial unit commands
    always_comb begin
        alu_cmd.go  = 1'b0;
        alu_cmd.div = 1'b0;
        alu_cmd.a   = '0;
        alu_cmd.b   = '0;
        case (state_reg)
            S_LOSS_GO: begin
                alu_cmd.go = 1'b1;
                alu_cmd.a  = ptps_pkg::OPA_W'(friction_reg);
                alu_cmd.b  = ptps_pkg::OPB_W'(period_reg);
            end
            S_LOSS_M, S_V_M: begin
                alu_cmd.go  = alu_st.done;
                alu_cmd.div = 1'b1;
                alu_cmd.a   = alu_res;
                alu_cmd.b   = ptps_pkg::OPB_W'(ptps_pkg::POS_DIV);
            end
            S_N_GO: begin
                alu_cmd.go = 1'b1;
                alu_cmd.a  = ptps_pkg::OPA_W'(frc_mag[35:0]);
                alu_cmd.b  = ptps_pkg::OPB_W'(noise_sel);
            end
            S_N_M: begin
                alu_cmd.go  = alu_st.done;
                alu_cmd.div = 1'b1;
                alu_cmd.a   = alu_res;
                alu_cmd.b   = ptps_pkg::OPB_W'(ptps_pkg::NOISE_DIV);
            end
            S_P_GO: begin
                alu_cmd.go = 1'b1;
                alu_cmd.a  = ptps_pkg::OPA_W'(frc_mag[35:0]);
                alu_cmd.b  = ptps_pkg::OPB_W'(period_reg);
            end
            S_P_M: begin
                alu_cmd.go  = alu_st.done;
                alu_cmd.div = 1'b1;
                alu_cmd.a   = alu_res;
                alu_cmd.b   = ptps_pkg::OPB_W'(ptps_pkg::VEL_DIV);
            end
            S_V_GO: begin
                alu_cmd.go = 1'b1;
                alu_cmd.a  = ptps_pkg::OPA_W'(v_mag);
                alu_cmd.b  = ptps_pkg::OPB_W'(period_reg);
            end
            S_G_GO: begin
                alu_cmd.go  = 1'b1;
                alu_cmd.div = 1'b1;
                alu_cmd.a   = ptps_pkg::OPA_W'(pos_mag);
                // a phase is at least 1 nm wide
                alu_cmd.b   = (enc_w == '0) ? ptps_pkg::OPB_W'(1)
                                            : ptps_pkg::OPB_W'(enc_w);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        neg_next      = neg_reg;
        frc_next      = frc_reg;
        v_next        = v_reg;
        loss_next     = loss_reg;
        period_next   = period_reg;
        pwx_next      = pwx_reg;
        pwy_next      = pwy_reg;
        req_next      = req_reg;
        nx_next       = nx_reg;
        ny_next       = ny_reg;
        pos_next      = pos_reg;
        speed_next    = speed_reg;
        enc_next      = enc_reg;
        failed_next   = failed_reg;
        ptl_next      = ptl_reg;
        count_next    = count_reg;
        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    period_next = s_tdata[15:0];
                    pwx_next    = s_tdata[23:16];
                    pwy_next    = s_tdata[31:24];
                    req_next    = req_in;
                    nx_next     = (nx_raw >= 10'(ptps_pkg::NOISE_MOD))
                                ? nx_raw - 10'(ptps_pkg::NOISE_MOD) : nx_raw;
                    ny_next     = (ny_raw >= 10'(ptps_pkg::NOISE_MOD))
                                ? ny_raw - 10'(ptps_pkg::NOISE_MOD) : ny_raw;
                    if (mode_in) begin
                        pos_next[0] = s_tdata[84:53];
                        pos_next[1] = s_tdata[116:85];
                        state_next  = S_REPORT;
                    end else if (failed_reg) begin
                        state_next = S_REPORT;
                    end else begin
                        state_next = S_LOSS_GO;
                    end
                end
            end
            S_LOSS_GO: state_next = S_LOSS_M;
            S_LOSS_M: begin
                if (alu_st.done) state_next = S_LOSS_D;
            end
            S_LOSS_D: begin
                if (alu_st.done) begin
                    loss_next  = alu_res[26:0];
                    axis_next  = 1'b0;
                    state_next = S_FORCE;
                end
            end
            S_FORCE: begin
                frc_next   = f37;
                state_next = S_N_GO;
            end
            S_N_GO: begin
                neg_next   = frc_reg[36];
                state_next = S_N_M;
            end
            S_N_M: begin
                if (alu_st.done) state_next = S_N_D;
            end
            S_N_D: begin
                if (alu_st.done) begin
                    frc_next   = neg_reg ? frc_reg - $signed(alu_res[36:0])
                                         : frc_reg + $signed(alu_res[36:0]);
                    state_next = S_P_GO;
                end
            end
            S_P_GO: begin
                neg_next   = frc_reg[36];
                state_next = S_P_M;
            end
            S_P_M: begin
                if (alu_st.done) state_next = S_P_D;
            end
            S_P_D: begin
                if (alu_st.done) begin
                    // speed wraps at 32 bits
                    v_next = neg_reg
                           ? speed_reg[axis_reg] - $signed(alu_res[31:0])
                           : speed_reg[axis_reg] + $signed(alu_res[31:0]);
                    state_next = S_FRIC;
                end
            end
            S_FRIC: begin
                v_next               = v_fric;
                speed_next[axis_reg] = v_fric;
                state_next           = S_V_GO;
            end
            S_V_GO: begin
                neg_next   = v_reg[31];
                state_next = S_V_M;
            end
            S_V_M: begin
                if (alu_st.done) state_next = S_V_D;
            end
            S_V_D: begin
                if (alu_st.done) begin
                    pos_next[axis_reg] = neg_reg
                        ? pos_reg[axis_reg] - $signed(alu_res[31:0])
                        : pos_reg[axis_reg] + $signed(alu_res[31:0]);
                    state_next = S_G_GO;
                end
            end
            S_G_GO: begin
                neg_next   = pos_reg[axis_reg][31];
                state_next = S_G_D;
            end
            S_G_D: begin
                if (alu_st.done) begin
                    // phase 0,1,2,3 -> Gray 00,01,11,10
                    enc_next[axis_reg] = {ph[1], ph[1] ^ ph[0]};
                    if (!axis_reg) begin
                        axis_next  = 1'b1;
                        state_next = S_FORCE;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (out_free) begin
                    failed_next           = chk_fail;
                    ptl_next              = chk_ptl;
                    count_next            = chk_count;
                    last_x_next           = chk_last_x;
                    last_y_next           = chk_last_y;
                    out_next.enc_x        = enc_reg[0];
                    out_next.enc_y        = enc_reg[1];
                    out_next.safe_left    = pos_reg[0][31];
                    out_next.safe_right   = px34 > $signed({4'b0, area_w_reg});
                    out_next.safe_top     = pos_reg[1][31];
                    out_next.safe_bottom  = py34 > $signed({4'b0, area_h_reg});
                    out_next.head_up      = chk_head;
                    out_next.fail_flag    = chk_fail;
                    out_next.punch_count  = chk_count;
                    out_next.last_punch_x = chk_last_x;
                    out_next.last_punch_y = chk_last_y;
                    m_tvalid_next         = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    out_next.enc_x        = enc_reg[0];
                    out_next.enc_y        = enc_reg[1];
                    out_next.safe_left    = pos_reg[0][31];
                    out_next.safe_right   = px34 > $signed({4'b0, area_w_reg});
                    out_next.safe_top     = pos_reg[1][31];
                    out_next.safe_bottom  = py34 > $signed({4'b0, area_h_reg});
                    out_next.head_up      = rep_head;
                    out_next.fail_flag    = failed_reg;
                    out_next.punch_count  = count_reg;
                    out_next.last_punch_x = last_x_reg;
                    out_next.last_punch_y = last_y_reg;
                    m_tvalid_next         = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            failed_reg     <= 1'b0;
            ptl_reg        <= '0;
            count_reg      <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            pos_reg[0]     <= '0;
            pos_reg[1]     <= '0;
            speed_reg[0]   <= '0;
            speed_reg[1]   <= '0;
            enc_reg[0]     <= '0;
            enc_reg[1]     <= '0;
            area_w_reg     <= 30'd100000000;
            area_h_reg     <= 30'd100000000;
            safe_zone_reg  <= 27'd1000000;
            punch_max_reg  <= 20'd100;
            enc_period_reg <= 20'd4000;
            friction_reg   <= 20'd1000;
            punch_dur_reg  <= 27'd100000;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            failed_reg   <= failed_next;
            ptl_reg      <= ptl_next;
            count_reg    <= count_next;
            last_x_reg   <= last_x_next;
            last_y_reg   <= last_y_next;
            pos_reg      <= pos_next;
            speed_reg    <= speed_next;
            enc_reg      <= enc_next;
            if (cfg_we) begin
                case (cfg_index)
                    ptps_pkg::REG_AREA_WIDTH:  area_w_reg     <= cfg_wdata;
                    ptps_pkg::REG_AREA_HEIGHT: area_h_reg     <= cfg_wdata;
                    ptps_pkg::REG_SAFE_ZONE:   safe_zone_reg  <= cfg_wdata[26:0];
                    ptps_pkg::REG_PUNCH_MAX:   punch_max_reg  <= cfg_wdata[19:0];
                    ptps_pkg::REG_ENC_PERIOD:  enc_period_reg <= cfg_wdata[19:0];
                    ptps_pkg::REG_FRICTION:    friction_reg   <= cfg_wdata[19:0];
                    ptps_pkg::REG_PUNCH_DUR:   punch_dur_reg  <= cfg_wdata[26:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        axis_reg   <= axis_next;
        neg_reg    <= neg_next;
        frc_reg    <= frc_next;
        v_reg      <= v_next;
        loss_reg   <= loss_next;
        period_reg <= period_next;
        pwx_reg    <= pwx_next;
        pwy_reg    <= pwy_next;
        req_reg    <= req_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_reg};

    a_fail_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |=> failed_reg)
        else $error("fail latch cleared without reset");

    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_CHECK || state_reg == S_REPORT) && out_free) |=> m_tvalid)
        else $error("finished step produced no result");

    a_alu_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_st.done |-> (state_reg == S_LOSS_M || state_reg == S_LOSS_D ||
                         state_reg == S_N_M || state_reg == S_N_D ||
                         state_reg == S_P_M || state_reg == S_P_D ||
                         state_reg == S_V_M || state_reg == S_V_D ||
                         state_reg == S_G_D))
        else $error("arithmetic result arrived outside a wait state");

    a_accept_alu_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !alu_st.busy)
        else $error("step accepted while arithmetic unit busy");

endmodule

// ===== design/ptps_muldiv.sv =====
// ---------------------------------------------------------------------------
// ptps_muldiv
// Bit-serial unsigned unit: shift-add multiply (one multiplier bit a cycle)
// or restoring divide (one quotient bit a cycle).
// ---------------------------------------------------------------------------
module ptps_muldiv (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ptps_pkg::alu_cmd_t               cmd,
    output ptps_pkg::alu_stat_t              stat,
    output logic [ptps_pkg::OPA_W-1:0]       result
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic                             div_reg, div_next;
    logic [ptps_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [ptps_pkg::OPA_W-1:0]       a_reg, a_next;
    logic [ptps_pkg::OPA_W-1:0]       acc_reg, acc_next;
    logic [ptps_pkg::OPB_W-1:0]       b_reg, b_next;
    logic [ptps_pkg::OPB_W-1:0]       rem_reg, rem_next;
    logic [ptps_pkg::OPB_W:0]         shifted;
    logic [ptps_pkg::OPB_W:0]         trial;
    logic                             qbit;

    assign shifted = {rem_reg, a_reg[ptps_pkg::OPA_W-1]};
    assign trial   = shifted - {1'b0, b_reg};
    assign qbit    = !trial[ptps_pkg::OPB_W];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        acc_next  = acc_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        if (cmd.go) begin
            busy_next = 1'b1;
            div_next  = cmd.div;
            a_next    = cmd.a;
            b_next    = cmd.b;
            acc_next  = '0;
            rem_next  = '0;
            cnt_next  = cmd.div ? ptps_pkg::CNT_W'(ptps_pkg::DIV_STEPS - 1)
                                : ptps_pkg::CNT_W'(ptps_pkg::MUL_STEPS - 1);
        end else if (busy_reg) begin
            if (div_reg) begin
                rem_next = qbit ? trial[ptps_pkg::OPB_W-1:0]
                                : shifted[ptps_pkg::OPB_W-1:0];
                a_next   = {a_reg[ptps_pkg::OPA_W-2:0], qbit};
            end else begin
                if (b_reg[0]) begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[ptps_pkg::OPA_W-2:0], 1'b0};
                b_next = {1'b0, b_reg[ptps_pkg::OPB_W-1:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg <= div_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        acc_reg <= acc_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = div_reg ? a_reg : acc_reg;

endmodule

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the punch table plant step: steps are sent in
// bursts, and each result is checked against a plant model inside the bench.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    typedef struct {
        bit               mode;
        bit [15:0]        period;
        bit signed [7:0]  power_x;
        bit signed [7:0]  power_y;
        bit               punch;
        bit [9:0]         noise_x;
        bit [9:0]         noise_y;
        bit signed [31:0] place_x;
        bit signed [31:0] place_y;
    } step_t;

    typedef struct {
        int          pos_x, pos_y, spd_x, spd_y;
        bit          failed;
        int          punch_left;
        int unsigned punches;
        int          last_x, last_y;
        bit [1:0]    enc_x, enc_y;
    } plant_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic [ptps_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ptps_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [ptps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ptps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    longint unsigned plant_reg[7];
    plant_t          plant;
    ptps_pkg::res_t  pending_results[$];
    int              errors = 0;
    int              burst_left = 0;
    int              idle_cycles = 0;

    punch_table_plant_step_top u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- plant model ----------------
    function automatic bit [1:0] gray_of(int pos);
        longint w = plant_reg[ptps_pkg::REG_ENC_PERIOD] / 4;
        longint q;
        bit [1:0] ph;
        if (w == 0) w = 1;
        q  = longint'(pos) / w;
        ph = q[1:0];
        if (ph == 2'd2) ph = 2'd3;
        else if (ph == 2'd3) ph = 2'd2;
        return ph;
    endfunction

    function automatic void move_axis(inout int pos, inout int spd, inout bit [1:0] enc,
                                      input longint pw, input longint nz, input longint per);
        longint force_v = (pw * ptps_pkg::FORCE_PER_POWER - longint'(spd)) * 5;
        longint v, mag, loss;
        force_v += (force_v * nz) / ptps_pkg::NOISE_DIV;
        v = longint'(int'(longint'(spd) + (force_v * per) / ptps_pkg::VEL_DIV));
        loss = longint'(plant_reg[ptps_pkg::REG_FRICTION]) * per / 1000;
        mag = v < 0 ? -v : v;
        if (mag <= 1 || mag <= loss) v = 0;
        else if (v < 0) v += loss;
        else v -= loss;
        spd = int'(v);
        pos = int'(longint'(pos) + (v * per) / ptps_pkg::POS_DIV);
        enc = gray_of(pos);
    endfunction

    function automatic bit off_table(int pos, longint lim);
        longint sz = plant_reg[ptps_pkg::REG_SAFE_ZONE];
        return longint'(pos) < -sz || longint'(pos) > lim + sz;
    endfunction

    function automatic bit too_fast(plant_t p);
        longint ax = p.spd_x < 0 ? -longint'(p.spd_x) : longint'(p.spd_x);
        longint ay = p.spd_y < 0 ? -longint'(p.spd_y) : longint'(p.spd_y);
        return ax > plant_reg[ptps_pkg::REG_PUNCH_MAX] ||
               ay > plant_reg[ptps_pkg::REG_PUNCH_MAX];
    endfunction

    function automatic ptps_pkg::res_t plant_step(inout plant_t p, input step_t it);
        longint per = it.period;
        longint nx = it.noise_x % ptps_pkg::NOISE_MOD;
        longint ny = it.noise_y % ptps_pkg::NOISE_MOD;
        bit head = 1'b0;
        ptps_pkg::res_t r;
        if (it.mode) begin
            p.pos_x = it.place_x;
            p.pos_y = it.place_y;
            head = p.punch_left == 0;
        end else if (p.failed) begin
            head = p.punch_left == 0;
        end else begin
            move_axis(p.pos_x, p.spd_x, p.enc_x, it.power_x, nx, per);
            move_axis(p.pos_y, p.spd_y, p.enc_y, it.power_y, ny, per);
            if (off_table(p.pos_x, plant_reg[ptps_pkg::REG_AREA_WIDTH]) ||
                off_table(p.pos_y, plant_reg[ptps_pkg::REG_AREA_HEIGHT]))
                p.failed = 1'b1;
            if (it.punch) begin
                if (p.punch_left > 0 || too_fast(p)) begin
                    p.failed = 1'b1;
                end else begin
                    p.last_x = p.pos_x;
                    p.last_y = p.pos_y;
                    p.punch_left = int'(plant_reg[ptps_pkg::REG_PUNCH_DUR]);
                end
            end else if (p.punch_left > 0) begin
                p.punch_left = int'(longint'(p.punch_left) - per);
                if (too_fast(p)) begin
                    p.failed = 1'b1;
                end else if (p.punch_left <= 0) begin
                    head = 1'b1;
                    p.punch_left = 0;
                    p.punches++;
                end
            end else begin
                head = 1'b1;
            end
        end
        r.enc_x        = p.enc_x;
        r.enc_y        = p.enc_y;
        r.safe_left    = p.pos_x < 0;
        r.safe_right   = longint'(p.pos_x) > longint'(plant_reg[ptps_pkg::REG_AREA_WIDTH]);
        r.safe_top     = p.pos_y < 0;
        r.safe_bottom  = longint'(p.pos_y) > longint'(plant_reg[ptps_pkg::REG_AREA_HEIGHT]);
        r.head_up      = head;
        r.fail_flag    = p.failed;
        r.punch_count  = p.punches;
        r.last_punch_x = p.last_x;
        r.last_punch_y = p.last_y;
        return r;
    endfunction

    // ---------------- result checker ----------------
    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        ptps_pkg::res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = ptps_pkg::res_t'(m_tdata[$bits(ptps_pkg::res_t)-1:0]);
            if (pending_results.size() == 0) begin
                $error("result transfer with no step outstanding");
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("enc_x", want.enc_x, got.enc_x);
                check_field("enc_y", want.enc_y, got.enc_y);
                check_field("safe_left", want.safe_left, got.safe_left);
                check_field("safe_right", want.safe_right, got.safe_right);
                check_field("safe_top", want.safe_top, got.safe_top);
                check_field("safe_bottom", want.safe_bottom, got.safe_bottom);
                check_field("head_up", want.head_up, got.head_up);
                check_field("fail_flag", want.fail_flag, got.fail_flag);
                check_field("punch_count", want.punch_count, got.punch_count);
                check_field("last_punch_x", want.last_punch_x, got.last_punch_x);
                check_field("last_punch_y", want.last_punch_y, got.last_punch_y);
            end
        end
    end

    // receiver back-pressure: quiet stretches alternate with random stalls
    int stall_left = 0;
    int ready_cycle = 0;
    always @(posedge aclk) begin
        ready_cycle <= ready_cycle + 1;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ((ready_cycle / 3000) % 2 == 1 && $urandom_range(7) == 0) begin
            stall_left <= $urandom_range(30);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog: no transfer on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles > STALL_LIMIT) begin
            $display("** punch_table_plant_step_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic send_step(step_t it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {3'b0, it.place_y, it.place_x, it.noise_y, it.noise_x, it.punch,
                     it.power_y, it.power_x, it.period};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(plant_step(plant, it));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [ptps_pkg::CFG_IDX_W-1:0] idx,
                             logic [ptps_pkg::CFG_DATA_W-1:0] val);
        const int reg_w[7] = '{30, 30, 27, 20, 20, 20, 27};
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx <= ptps_pkg::REG_PUNCH_DUR)
            plant_reg[idx] = val & ((64'd1 << reg_w[idx]) - 1);
        @(posedge aclk);
    endtask

    function automatic step_t place_inside();
        step_t it = '{default: 0};
        it.mode    = 1'b1;
        it.place_x = $urandom_range(int'(plant_reg[ptps_pkg::REG_AREA_WIDTH]));
        it.place_y = $urandom_range(int'(plant_reg[ptps_pkg::REG_AREA_HEIGHT]));
        it.period  = 16'($urandom);
        it.power_x = 8'($urandom);
        it.noise_y = 10'($urandom);
        return it;
    endfunction

    function automatic step_t rand_tick();
        step_t it;
        it.mode    = 1'b0;
        it.period  = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2000));
        it.power_x = $urandom_range(1) ? 8'sd0 : 8'($urandom);
        it.power_y = $urandom_range(1) ? 8'sd0 : 8'($urandom);
        it.punch   = $urandom_range(2) == 0;
        it.noise_x = $urandom_range(7) == 0 ? 10'($urandom_range(1000, 1023))
                                            : 10'($urandom_range(999));
        it.noise_y = 10'($urandom);
        it.place_x = $urandom;
        it.place_y = $urandom;
        return it;
    endfunction

    // keeps the table healthy: a step that would fail loses its punch request,
    // or else becomes a placement back inside the area
    task automatic send_healthy(step_t it);
        plant_t trial = plant;
        ptps_pkg::res_t r = plant_step(trial, it);
        if (r.fail_flag && !it.mode) begin
            it.punch = 1'b0;
            trial = plant;
            r = plant_step(trial, it);
            if (r.fail_flag) it = place_inside();
        end
        send_step(it);
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        step_t it = '{default: 0};
        it.punch = 1'b1;                       // punch from rest
        send_step(it);
        it.punch = 1'b0;
        it.period = 16'hFFFF;                  // two long ticks finish the punch
        send_step(it);
        send_step(it);
        it = '{default: 0};
        it.mode = 1'b1;
        it.place_x = 32'sh8000_0000;
        it.place_y = 32'sh7FFF_FFFF;
        send_step(it);
        it.place_x = 32'sh7FFF_FFFF;
        it.place_y = 32'sh8000_0000;
        send_step(it);
        it.place_x = -32'sd1;
        it.place_y = -32'sd1;
        send_step(it);
        it.place_x = 50000000;
        it.place_y = 50000000;
        send_step(it);
        it = '{default: 0};
        send_step(it);                         // zero period tick
        it.period  = 16'hFFFF;
        it.power_x = 8'sd127;
        it.power_y = -8'sd128;
        it.noise_x = 10'd999;
        it.noise_y = 10'd1023;
        send_step(it);
        it.power_x = -8'sd128;
        it.power_y = 8'sd127;
        it.noise_x = 10'd1023;
        it.noise_y = 10'd0;
        send_step(it);
        it.power_x = 8'sd0;
        it.power_y = 8'sd0;
        it.noise_x = 10'd1000;
        it.noise_y = 10'd999;
        repeat (4) send_healthy(it);
        drain();
    endtask

    task automatic test_random(int n);
        repeat (n) begin
            if ($urandom_range(15) == 0) send_healthy(place_inside());
            else send_healthy(rand_tick());
        end
        drain();
    endtask

    task automatic test_edge_registers();
        write_reg(ptps_pkg::REG_AREA_WIDTH, 30'd1);
        write_reg(ptps_pkg::REG_AREA_HEIGHT, 30'd1);
        write_reg(ptps_pkg::REG_SAFE_ZONE, 30'd100000000);
        write_reg(ptps_pkg::REG_PUNCH_MAX, 30'd1000000);
        write_reg(ptps_pkg::REG_ENC_PERIOD, 30'd4);
        write_reg(ptps_pkg::REG_FRICTION, 30'd0);
        write_reg(ptps_pkg::REG_PUNCH_DUR, 30'd0);
        write_reg(3'd7, 30'h2AAAAAAA);        // unused index, must be ignored
        test_random(200);
        write_reg(ptps_pkg::REG_AREA_WIDTH, 30'h3FFFFFFF);
        write_reg(ptps_pkg::REG_AREA_HEIGHT, 30'd1000000000);
        write_reg(ptps_pkg::REG_SAFE_ZONE, 30'd0);
        write_reg(ptps_pkg::REG_PUNCH_MAX, 30'd0);
        write_reg(ptps_pkg::REG_ENC_PERIOD, 30'd0);     // below four: one-nm phase
        write_reg(ptps_pkg::REG_FRICTION, 30'd1000000);
        write_reg(ptps_pkg::REG_PUNCH_DUR, 30'd100000000);
        send_healthy(place_inside());
        test_random(200);
    endtask

    task automatic test_random_registers();
        write_reg(ptps_pkg::REG_AREA_WIDTH, 30'($urandom_range(1000, 1000000000)));
        write_reg(ptps_pkg::REG_AREA_HEIGHT, 30'($urandom_range(1000, 1000000000)));
        write_reg(ptps_pkg::REG_SAFE_ZONE, 30'($urandom_range(100000000)));
        write_reg(ptps_pkg::REG_PUNCH_MAX, 30'($urandom_range(50000)));
        write_reg(ptps_pkg::REG_ENC_PERIOD, 30'($urandom_range(4, 1000000)));
        write_reg(ptps_pkg::REG_FRICTION, 30'($urandom_range(20000)));
        write_reg(ptps_pkg::REG_PUNCH_DUR, 30'($urandom_range(200000)));
        send_healthy(place_inside());
        test_random(250);
    endtask

    // deliberate faults: punch while moving fast, then a dead table
    task automatic test_faults();
        step_t it = '{default: 0};
        it.period  = 16'd5000;
        it.power_x = 8'sd127;
        it.punch   = 1'b1;
        send_step(it);
        it.mode    = 1'b1;
        it.place_x = -32'sd2000000000;
        send_step(it);
        repeat (60) begin
            if ($urandom_range(3) == 0) begin
                it = place_inside();
                it.place_x = $urandom;
            end else begin
                it = rand_tick();
            end
            send_step(it);
        end
        drain();
    endtask

    initial begin
        plant_reg = '{100000000, 100000000, 1000000, 100, 4000, 1000, 100000};
        plant = '{default: 0};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(230);
        test_edge_registers();
        test_random_registers();
        test_faults();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("** punch_table_plant_step_top: PASSED **");
        else
            $display("** punch_table_plant_step_top: FAILED **");
        $finish;
    end

endmodule

// ===== punch_table_plant_step_top.f =====
design/ptps_pkg.sv
design/ptps_muldiv.sv
design/punch_table_plant_step_top.sv
test/tb.sv
